// ----- hw/rtl/agpm_pkg.sv -----
`default_nettype none

package agpm_pkg;

    // Fixed widths of the configuration and state fields
    localparam int ENERGY_W  = 32;
    localparam int PHASE_W   = 10;
    localparam int STEP_W    = 16;
    localparam int QUIET_W   = 3;
    localparam int RUN_W     = 3;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;

    // Reset values
    localparam int unsigned INIT_GAIN_RST = 5243;   // 0.08 in Q4.16
    localparam logic [STEP_W-1:0]   GAIN_STEP_RST = 16'd66;
    localparam logic [PHASE_W-1:0]  PERIOD_RST    = 10'd100;
    localparam logic [QUIET_W-1:0]  QUIET_RST     = 3'd3;
    localparam logic [ENERGY_W-1:0] PRIOR_RST     = 32'd1000000000;
    localparam logic [RUN_W-1:0]    RUN_MAX       = 3'd7;

    // Divide by six: multiply by ceil(2^18 / 6), exact for magnitudes below 2^16
    localparam int DIV6_SHIFT = 18;
    localparam int unsigned DIV6_MUL = 43691;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_GAIN  = 2'd0,
        CFG_GAIN_STEP     = 2'd1,
        CFG_WINDOW_PERIOD = 2'd2,
        CFG_QUIET_LIMIT   = 2'd3
    } cfg_idx_t;

endpackage

`default_nettype wire

// ----- hw/rtl/agpm_in_if.sv -----
`default_nettype none

interface agpm_in_if #(
    parameter int OW = 11
);
    logic                 valid;
    logic                 ready;
    logic signed [OW-1:0] offset_x;
    logic signed [OW-1:0] offset_y;

    modport source (output valid, output offset_x, output offset_y, input ready);
    modport sink   (input valid, input offset_x, input offset_y, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/agpm_out_if.sv -----
`default_nettype none

interface agpm_out_if #(
    parameter int OW = 11,
    parameter int GW = 20
);
    logic                 valid;
    logic                 ready;
    logic signed [OW-1:0] move_x;
    logic signed [OW-1:0] move_y;
    logic                 used_fallback;
    logic [GW-1:0]        gain_now;

    modport source (output valid, output move_x, output move_y, output used_fallback,
                    output gain_now, input ready);
    modport sink   (input valid, input move_x, input move_y, input used_fallback,
                    input gain_now, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/agpm_gain.sv -----
`default_nettype none

module agpm_gain
    import agpm_pkg::*;
#(
    parameter int OW = 11,
    parameter int GW = 20
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire logic signed [OW-1:0] x,
    input  wire logic signed [OW-1:0] y,
    input  wire logic [2*OW-1:0]      e,
    input  wire logic [STEP_W-1:0]    gain_step,
    input  wire logic [PHASE_W-1:0]   window_period,
    output logic [GW-1:0]             gain_cur,
    output logic [GW-1:0]             gain_new,
    output logic signed [OW-1:0]      q6_x,
    output logic signed [OW-1:0]      q6_y
);

    localparam int SW = ((GW > STEP_W) ? GW : STEP_W) + 1;
    localparam int PW = OW + DIV6_SHIFT;
    localparam logic [SW-1:0] GMAX_EXT = {{(SW-GW){1'b0}}, {GW{1'b1}}};

    logic [ENERGY_W-1:0] energy_reg;
    logic [ENERGY_W-1:0] prior_reg;
    logic [PHASE_W-1:0]  phase_reg;
    logic [GW-1:0]       gain_reg;

    logic [ENERGY_W:0]   sum;
    logic [ENERGY_W-1:0] esat;
    logic [PHASE_W:0]    phase_inc;
    logic [PHASE_W-1:0]  phase_next;
    logic                win_end;
    logic [SW-1:0]       g_ext;
    logic [SW-1:0]       s_ext;
    logic [SW-1:0]       fall;
    logic [SW-1:0]       rise_sum;
    logic [SW-1:0]       rise;
    logic [GW-1:0]       gain_next;

    // Truncating divide by six of a signed offset
    function automatic logic signed [OW-1:0] div6(input logic signed [OW-1:0] v);
        logic [OW-1:0] mag;
        logic [PW-1:0] prod;
        logic [OW-1:0] q;
        mag  = v[OW-1] ? (~v + 1'b1) : v;
        prod = PW'(mag) * PW'(DIV6_MUL);
        q    = prod[DIV6_SHIFT +: OW];
        return v[OW-1] ? $signed(~q + 1'b1) : $signed(q);
    endfunction

    always_comb
    begin
        sum  = {1'b0, energy_reg} + (ENERGY_W+1)'(e);
        esat = sum[ENERGY_W] ? {ENERGY_W{1'b1}} : sum[ENERGY_W-1:0];

        phase_inc  = {1'b0, phase_reg} + (PHASE_W+1)'(1);
        phase_next = (phase_inc >= {1'b0, window_period}) ? '0 : phase_inc[PHASE_W-1:0];
        win_end    = (phase_next == (window_period - PHASE_W'(1)));

        g_ext    = SW'(gain_reg);
        s_ext    = SW'(gain_step);
        fall     = (g_ext > s_ext) ? (g_ext - s_ext) : '0;
        rise_sum = g_ext + s_ext;
        rise     = (rise_sum > GMAX_EXT) ? GMAX_EXT : rise_sum;

        gain_next = gain_reg;
        if (win_end)
        begin
            gain_next = (esat > prior_reg) ? fall[GW-1:0] : rise[GW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg <= '0;
            prior_reg  <= PRIOR_RST;
            phase_reg  <= '0;
            gain_reg   <= GW'(INIT_GAIN_RST);
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            gain_reg  <= gain_next;
            if (win_end)
            begin
                prior_reg  <= esat;
                energy_reg <= '0;
            end
            else
            begin
                energy_reg <= esat;
            end
        end
    end

    assign gain_cur = gain_reg;
    assign gain_new = gain_next;
    assign q6_x     = div6(x);
    assign q6_y     = div6(y);

endmodule

`default_nettype wire

// ----- hw/rtl/agpm_scale.sv -----
`default_nettype none

module agpm_scale
    import agpm_pkg::*;
#(
    parameter int OW = 11,
    parameter int GW = 20,
    parameter int F  = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire logic signed [OW-1:0] x,
    input  wire logic signed [OW-1:0] y,
    input  wire logic signed [OW-1:0] q6_x,
    input  wire logic signed [OW-1:0] q6_y,
    input  wire logic [GW-1:0]        gain,
    input  wire logic [QUIET_W-1:0]   quiet_limit,
    output logic signed [OW-1:0]      move_x,
    output logic signed [OW-1:0]      move_y,
    output logic                      used_fallback
);

    localparam int PW = OW + GW;
    localparam int QW = PW - F;
    localparam logic [QW-1:0] POS_LIM = QW'((1 << (OW-1)) - 1);
    localparam logic [QW-1:0] NEG_LIM = QW'(1 << (OW-1));
    localparam logic [OW-1:0] MOVE_MAX = {1'b0, {(OW-1){1'b1}}};
    localparam logic [OW-1:0] MOVE_MIN = {1'b1, {(OW-1){1'b0}}};

    logic [RUN_W-1:0] run_reg;
    logic [RUN_W-1:0] run_next;
    logic [QW-1:0]    qx;
    logic [QW-1:0]    qy;
    logic             fb;

    // |v| * gain with the fraction dropped
    function automatic logic [QW-1:0] scale_mag(input logic signed [OW-1:0] v,
                                                input logic [GW-1:0] g);
        logic [OW-1:0] mag;
        logic [PW-1:0] prod;
        mag  = v[OW-1] ? (~v + 1'b1) : v;
        prod = PW'(mag) * PW'(g);
        return prod[F +: QW];
    endfunction

    // Put the sign back and clamp to the move range
    function automatic logic signed [OW-1:0] clamp(input logic neg, input logic [QW-1:0] q);
        logic [OW-1:0] r;
        if (!neg)
        begin
            r = (q > POS_LIM) ? MOVE_MAX : q[OW-1:0];
        end
        else
        begin
            r = (q >= NEG_LIM) ? MOVE_MIN : (~q[OW-1:0] + 1'b1);
        end
        return $signed(r);
    endfunction

    always_comb
    begin
        qx = scale_mag(x, gain);
        qy = scale_mag(y, gain);
        if ((qx == '0) && (qy == '0))
        begin
            run_next = (run_reg == RUN_MAX) ? RUN_MAX : (run_reg + RUN_W'(1));
        end
        else
        begin
            run_next = '0;
        end
        fb     = (run_next > RUN_W'(quiet_limit));
        move_x = fb ? q6_x : clamp(x[OW-1], qx);
        move_y = fb ? q6_y : clamp(y[OW-1], qy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
        end
        else if (fire)
        begin
            run_reg <= run_next;
        end
    end

    assign used_fallback = fb;

endmodule

`default_nettype wire

// ----- hw/rtl/adaptive_gain_pointer_motion.sv -----
// Adaptive-gain pointer motion.
// Input channel in_ch: one beat per frame carrying the signed target offset
// (offset_x, offset_y). Output channel out_ch: one beat per input beat with the
// pointer move, a flag set when the move is the offset divided by six, and the
// gain used (unsigned Q4.GAIN_FRAC_BITS, after any window update made by that
// frame). Both channels use valid/ready; a beat moves when both are high.
// Configuration: cfg_wr_en, cfg_index, cfg_data; write only while idle. The
// initial gain is loaded by reset, so a later write to it has no visible effect.
// Pipeline: an input beat passes the capture register, the window/gain stage and
// the scaling stage into the result register.
// Throughput: one beat per cycle while out_ch.ready is high; the only loops are
// the updates of the energy/gain state and of the zero-move run counter.
// Reset clears every stage, sets the gain to its reset value, the window phase
// and energy to zero and the prior window energy to 1e9.
// When out_ch.ready is low the result is held, the stages behind it fill, and
// in_ch.ready drops once all three are full; nothing is lost or repeated.
`default_nettype none

module adaptive_gain_pointer_motion
    import agpm_pkg::*;
#(
    parameter int OFFSET_WIDTH   = 11,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    agpm_in_if.sink                   in_ch,
    agpm_out_if.source                out_ch,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int OW = OFFSET_WIDTH;
    localparam int GW = GAIN_FRAC_BITS + 4;
    localparam int EW = 2 * OW;
    // Largest magnitude a divide-by-six move can have
    localparam logic signed [OW-1:0] FB_LIM = OW'((1 << (OW-1)) / 6);

    // Configuration registers
    logic [STEP_W-1:0]  step_reg;
    logic [PHASE_W-1:0] period_reg;
    logic [QUIET_W-1:0] quiet_reg;

    // Capture stage
    logic                 a_valid_reg;
    logic signed [OW-1:0] x_a_reg;
    logic signed [OW-1:0] y_a_reg;
    logic [EW-1:0]        e_a_reg;

    // Gain stage output
    logic                 b_valid_reg;
    logic signed [OW-1:0] x_b_reg;
    logic signed [OW-1:0] y_b_reg;
    logic signed [OW-1:0] q6x_b_reg;
    logic signed [OW-1:0] q6y_b_reg;
    logic [GW-1:0]        gain_b_reg;

    // Result register
    logic                 c_valid_reg;
    logic signed [OW-1:0] move_x_reg;
    logic signed [OW-1:0] move_y_reg;
    logic                 fb_reg;
    logic [GW-1:0]        gain_c_reg;

    logic                 c_free;
    logic                 b_free;
    logic                 a_free;
    logic                 a_adv;
    logic                 b_adv;
    logic                 in_fire;

    logic signed [EW-1:0] sq_x;
    logic signed [EW-1:0] sq_y;
    logic [EW-1:0]        e_in;

    logic [GW-1:0]        gain_cur;
    logic [GW-1:0]        gain_new;
    logic signed [OW-1:0] q6_x;
    logic signed [OW-1:0] q6_y;
    logic signed [OW-1:0] mv_x;
    logic signed [OW-1:0] mv_y;
    logic                 mv_fb;

    // Flow control: a stage takes a beat when it is empty or its beat leaves
    assign c_free  = !c_valid_reg || out_ch.ready;
    assign b_free  = !b_valid_reg || c_free;
    assign a_free  = !a_valid_reg || b_free;
    assign a_adv   = a_valid_reg && b_free;
    assign b_adv   = b_valid_reg && c_free;
    assign in_fire = in_ch.valid && a_free;

    assign in_ch.ready = a_free;

    // Offset energy, squared ahead of the capture register
    assign sq_x = EW'(in_ch.offset_x) * EW'(in_ch.offset_x);
    assign sq_y = EW'(in_ch.offset_y) * EW'(in_ch.offset_y);
    assign e_in = $unsigned(sq_x) + $unsigned(sq_y);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= GAIN_STEP_RST;
            period_reg <= PERIOD_RST;
            quiet_reg  <= QUIET_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_INITIAL_GAIN:  ;    // taken only at reset
                CFG_GAIN_STEP:     step_reg   <= cfg_data[STEP_W-1:0];
                CFG_WINDOW_PERIOD: period_reg <= cfg_data[PHASE_W-1:0];
                CFG_QUIET_LIMIT:   quiet_reg  <= cfg_data[QUIET_W-1:0];
                default:           ;
            endcase
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
            begin
                a_valid_reg <= in_ch.valid;
            end
            if (b_free)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_free)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    // Payload: capture the beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_a_reg <= in_ch.offset_x;
            y_a_reg <= in_ch.offset_y;
            e_a_reg <= e_in;
        end
    end

    // Energy accumulation, window compare and gain update
    agpm_gain #(
        .OW (OW),
        .GW (GW)
    ) u_gain (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (a_adv),
        .x             (x_a_reg),
        .y             (y_a_reg),
        .e             (e_a_reg),
        .gain_step     (step_reg),
        .window_period (period_reg),
        .gain_cur      (gain_cur),
        .gain_new      (gain_new),
        .q6_x          (q6_x),
        .q6_y          (q6_y)
    );

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            x_b_reg    <= x_a_reg;
            y_b_reg    <= y_a_reg;
            q6x_b_reg  <= q6_x;
            q6y_b_reg  <= q6_y;
            gain_b_reg <= gain_new;
        end
    end

    // Scaling, zero-move run and fallback select
    agpm_scale #(
        .OW (OW),
        .GW (GW),
        .F  (GAIN_FRAC_BITS)
    ) u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (b_adv),
        .x             (x_b_reg),
        .y             (y_b_reg),
        .q6_x          (q6x_b_reg),
        .q6_y          (q6y_b_reg),
        .gain          (gain_b_reg),
        .quiet_limit   (quiet_reg),
        .move_x        (mv_x),
        .move_y        (mv_y),
        .used_fallback (mv_fb)
    );

    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            move_x_reg <= mv_x;
            move_y_reg <= mv_y;
            fb_reg     <= mv_fb;
            gain_c_reg <= gain_b_reg;
        end
    end

    assign out_ch.valid         = c_valid_reg;
    assign out_ch.move_x        = move_x_reg;
    assign out_ch.move_y        = move_y_reg;
    assign out_ch.used_fallback = fb_reg;
    assign out_ch.gain_now      = gain_c_reg;

    // Gain state moves only when the gain stage takes a beat
    a_gain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !a_adv |=> $stable(gain_cur))
        else $error("gain changed without a beat in the gain stage");

    // A beat leaving the scaling stage is in the result register next cycle
    a_b_to_c: assert property (@(posedge clk) disable iff (!rst_n)
        b_adv |=> c_valid_reg)
        else $error("beat lost between scaling stage and result register");

    // A fallback move is a sixth of an offset and stays small
    a_fb_range: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && fb_reg) |->
            (move_x_reg <= FB_LIM) && (move_x_reg >= -FB_LIM) &&
            (move_y_reg <= FB_LIM) && (move_y_reg >= -FB_LIM))
        else $error("fallback move out of range");

endmodule

`default_nettype wire
